FILE: design/rca_pkg.sv
// Shared types and constants for the redundant command arbiter.
package rca_pkg;

    localparam int TIME_BITS      = 32;
    localparam int STEP_BITS      = 10;
    localparam int CFG_BITS       = 16;
    localparam int CMD_BITS       = 16;
    localparam int FLAG_BITS      = 3;
    localparam int CFG_INDEX_BITS = 3;
    localparam int RATE_SHIFT     = 10;

    localparam int FLAG_RX   = 0;
    localparam int FLAG_NOM  = 1;
    localparam int FLAG_AEB  = 2;

    localparam logic [CFG_BITS-1:0] RST_FRESH_TIMEOUT = CFG_BITS'(205);
    localparam logic [CFG_BITS-1:0] RST_RECOVER_HOLD  = CFG_BITS'(1024);
    localparam logic [CFG_BITS-1:0] RST_GUARD_LENGTH  = CFG_BITS'(512);
    localparam logic [CFG_BITS-1:0] RST_STEER_NORMAL  = CFG_BITS'(2048);
    localparam logic [CFG_BITS-1:0] RST_STEER_GUARD   = CFG_BITS'(1024);
    localparam logic [CFG_BITS-1:0] RST_ACCEL_NORMAL  = CFG_BITS'(1536);
    localparam logic [CFG_BITS-1:0] RST_ACCEL_GUARD   = CFG_BITS'(768);
    localparam logic [CFG_BITS-1:0] RST_BRAKE_EMERG   = CFG_BITS'(10240);

    typedef enum logic [1:0] {
        ROLE_NONE = 2'd0,
        ROLE_PRI  = 2'd1,
        ROLE_BAK  = 2'd2
    } t_role;

    typedef enum logic [2:0] {
        RSN_NONE          = 3'd0,
        RSN_PRI_DEGRADED  = 3'd1,
        RSN_PRI_LOST      = 3'd2,
        RSN_BOTH_BAD      = 3'd3,
        RSN_RECOVERED     = 3'd4,
        RSN_BAK_LOST      = 3'd5,
        RSN_ALL_LOST      = 3'd6
    } t_reason;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_FRESH_TIMEOUT = 3'd0,
        CFG_RECOVER_HOLD  = 3'd1,
        CFG_GUARD_LENGTH  = 3'd2,
        CFG_STEER_NORMAL  = 3'd3,
        CFG_STEER_GUARD   = 3'd4,
        CFG_ACCEL_NORMAL  = 3'd5,
        CFG_ACCEL_GUARD   = 3'd6,
        CFG_BRAKE_EMERG   = 3'd7
    } t_cfg_index;

    typedef struct packed {
        logic                 bypass;
        logic                 brake;
        logic [STEP_BITS-1:0] step;
        logic [CFG_BITS-1:0]  rate_up;
        logic [CFG_BITS-1:0]  rate_dn;
        logic [CFG_BITS-1:0]  rate_brake;
    } t_slew_cfg;

endpackage

FILE: design/rca_slew.sv
// Slew limiter for one command channel against the previous output.
module rca_slew import rca_pkg::*; (
    input  t_slew_cfg                   i_cfg,
    input  logic signed [CMD_BITS-1:0]  i_prev,
    input  logic signed [CMD_BITS-1:0]  i_target,
    output logic signed [CMD_BITS-1:0]  o_value
);

    localparam int PROD_BITS = CFG_BITS + STEP_BITS;

    logic signed [CMD_BITS+1:0] diff;
    logic signed [CMD_BITS+1:0] lim_up;
    logic signed [CMD_BITS+1:0] lim_dn;
    logic signed [CMD_BITS+1:0] delta;
    logic signed [CMD_BITS+1:0] sum;
    logic [CFG_BITS-1:0]        dn_rate;
    logic [PROD_BITS-1:0]       prod_up;
    logic [PROD_BITS-1:0]       prod_dn;

    always_comb begin
        diff    = (CMD_BITS+2)'(i_target) - (CMD_BITS+2)'(i_prev);
        dn_rate = (i_cfg.brake && diff[CMD_BITS+1]) ? i_cfg.rate_brake : i_cfg.rate_dn;
        prod_up = PROD_BITS'(i_cfg.rate_up) * PROD_BITS'(i_cfg.step);
        prod_dn = PROD_BITS'(dn_rate) * PROD_BITS'(i_cfg.step);
        lim_up  = signed'({2'b00, prod_up[PROD_BITS-1:RATE_SHIFT]});
        lim_dn  = signed'({2'b00, prod_dn[PROD_BITS-1:RATE_SHIFT]});
        if (diff > lim_up) begin
            delta = lim_up;
        end else if (diff < -lim_dn) begin
            delta = -lim_dn;
        end else begin
            delta = diff;
        end
        // result lies between previous and target, so it always fits
        sum     = (CMD_BITS+2)'(i_prev) + delta;
        o_value = i_cfg.bypass ? i_target : sum[CMD_BITS-1:0];
    end

endmodule

FILE: design/redundant_command_arbiter.sv
// Redundant command arbiter: source selection, failover and slew-limited output.
// Pipeline: input register, then result register; role, timer and previous-output state
// update in one pass. Throughput: one request per cycle unless i_ready stalls the output.
// Reset: synchronous active-low i_rst_n clears the pipeline, role state and previous output,
// and loads every configuration register with its default.
module redundant_command_arbiter import rca_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  logic [CFG_BITS-1:0]         i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [TIME_BITS-1:0]        i_now_time,
    input  logic [STEP_BITS-1:0]        i_step_time,
    input  logic [FLAG_BITS-1:0]        i_primary_flags,
    input  logic [TIME_BITS-1:0]        i_primary_stamp,
    input  logic signed [CMD_BITS-1:0]  i_primary_steer,
    input  logic signed [CMD_BITS-1:0]  i_primary_accel,
    input  logic [FLAG_BITS-1:0]        i_backup_flags,
    input  logic [TIME_BITS-1:0]        i_backup_stamp,
    input  logic signed [CMD_BITS-1:0]  i_backup_steer,
    input  logic signed [CMD_BITS-1:0]  i_backup_accel,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_cmd_valid,
    output logic [1:0]                  o_chosen_role,
    output logic signed [CMD_BITS-1:0]  o_out_steer,
    output logic signed [CMD_BITS-1:0]  o_out_accel,
    output logic                        o_in_guard,
    output logic [2:0]                  o_reason_code
);

    // configuration
    logic [CFG_BITS-1:0] r_fresh_timeout, r_recover_hold, r_guard_length;
    logic [CFG_BITS-1:0] r_steer_normal, r_steer_guard;
    logic [CFG_BITS-1:0] r_accel_normal, r_accel_guard, r_brake_emerg;

    // input register
    logic                        r_in_valid;
    logic [TIME_BITS-1:0]        r_now;
    logic [STEP_BITS-1:0]        r_step;
    logic [FLAG_BITS-1:0]        r_pflags, r_bflags;
    logic [TIME_BITS-1:0]        r_pstamp, r_bstamp;
    logic signed [CMD_BITS-1:0]  r_psteer, r_paccel, r_bsteer, r_baccel;

    // arbiter state
    t_role                       r_role;
    logic                        r_nrv;
    logic [TIME_BITS-1:0]        r_since;
    logic [TIME_BITS-1:0]        r_guard_end;
    logic signed [CMD_BITS-1:0]  r_prev_steer, r_prev_accel;
    logic                        r_have_prev;

    // result register
    logic                        r_out_valid;
    logic                        r_cmd_valid;
    t_role                       r_chosen;
    logic signed [CMD_BITS-1:0]  r_out_steer, r_out_accel;
    logic                        r_in_guard;
    t_reason                     r_reason;

    logic                        adv, step_en;
    logic [TIME_BITS-1:0]        p_age, b_age, since_eff, run, n_guard_end;
    logic                        p_fresh, b_fresh, p_nom, b_nom, pri_stable;
    t_role                       target;
    t_reason                     reason;
    logic                        guard, aeb;
    logic signed [CMD_BITS-1:0]  sel_steer, sel_accel, n_steer, n_accel;
    t_slew_cfg                   steer_cfg, accel_cfg;

    assign adv     = !r_out_valid || i_ready;
    assign o_ready = !r_in_valid || adv;
    assign step_en = r_in_valid && adv;

    always_comb begin
        p_age   = r_now - r_pstamp;
        b_age   = r_now - r_bstamp;
        p_fresh = r_pflags[FLAG_RX]
                  && (p_age[TIME_BITS-1] || p_age < TIME_BITS'(r_fresh_timeout));
        b_fresh = r_bflags[FLAG_RX]
                  && (b_age[TIME_BITS-1] || b_age < TIME_BITS'(r_fresh_timeout));
        p_nom   = p_fresh && r_pflags[FLAG_NOM];
        b_nom   = b_fresh && r_bflags[FLAG_NOM];

        since_eff  = r_nrv ? r_since : r_now;
        run        = r_now - since_eff;
        pri_stable = p_nom && !run[TIME_BITS-1] && run >= TIME_BITS'(r_recover_hold);

        target = ROLE_NONE;
        reason = RSN_NONE;
        if (r_role == ROLE_PRI || r_role == ROLE_NONE) begin
            priority if (p_nom) begin
                target = ROLE_PRI;
            end else if (b_nom) begin
                target = ROLE_BAK;
                reason = p_fresh ? RSN_PRI_DEGRADED : RSN_PRI_LOST;
            end else if (p_fresh) begin
                target = ROLE_PRI;
            end else if (b_fresh) begin
                target = ROLE_BAK;
                reason = RSN_BOTH_BAD;
            end
        end else begin
            priority if (pri_stable) begin
                target = ROLE_PRI;
                reason = RSN_RECOVERED;
            end else if (b_fresh) begin
                target = ROLE_BAK;
            end else if (p_fresh) begin
                target = ROLE_PRI;
                reason = RSN_BAK_LOST;
            end
        end

        // a source change reopens the takeover window
        n_guard_end = r_guard_end;
        if (target != ROLE_NONE && target != r_role && r_role != ROLE_NONE) begin
            n_guard_end = r_now + TIME_BITS'(r_guard_length);
        end
        guard = r_now < n_guard_end;

        if (target == ROLE_BAK) begin
            sel_steer = r_bsteer;
            sel_accel = r_baccel;
            aeb       = r_bflags[FLAG_AEB];
        end else begin
            sel_steer = r_psteer;
            sel_accel = r_paccel;
            aeb       = r_pflags[FLAG_AEB];
        end

        steer_cfg.bypass     = !r_have_prev;
        steer_cfg.brake      = 1'b0;
        steer_cfg.step       = r_step;
        steer_cfg.rate_up    = guard ? r_steer_guard : r_steer_normal;
        steer_cfg.rate_dn    = steer_cfg.rate_up;
        steer_cfg.rate_brake = steer_cfg.rate_up;

        accel_cfg.bypass     = !r_have_prev;
        accel_cfg.brake      = aeb;
        accel_cfg.step       = r_step;
        accel_cfg.rate_up    = guard ? r_accel_guard : r_accel_normal;
        accel_cfg.rate_dn    = accel_cfg.rate_up;
        accel_cfg.rate_brake = r_brake_emerg;
    end

    rca_slew u_steer (
        .i_cfg    (steer_cfg),
        .i_prev   (r_prev_steer),
        .i_target (sel_steer),
        .o_value  (n_steer)
    );

    rca_slew u_accel (
        .i_cfg    (accel_cfg),
        .i_prev   (r_prev_accel),
        .i_target (sel_accel),
        .o_value  (n_accel)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh_timeout <= RST_FRESH_TIMEOUT;
            r_recover_hold  <= RST_RECOVER_HOLD;
            r_guard_length  <= RST_GUARD_LENGTH;
            r_steer_normal  <= RST_STEER_NORMAL;
            r_steer_guard   <= RST_STEER_GUARD;
            r_accel_normal  <= RST_ACCEL_NORMAL;
            r_accel_guard   <= RST_ACCEL_GUARD;
            r_brake_emerg   <= RST_BRAKE_EMERG;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_FRESH_TIMEOUT: r_fresh_timeout <= i_cfg_data;
                CFG_RECOVER_HOLD:  r_recover_hold  <= i_cfg_data;
                CFG_GUARD_LENGTH:  r_guard_length  <= i_cfg_data;
                CFG_STEER_NORMAL:  r_steer_normal  <= i_cfg_data;
                CFG_STEER_GUARD:   r_steer_guard   <= i_cfg_data;
                CFG_ACCEL_NORMAL:  r_accel_normal  <= i_cfg_data;
                CFG_ACCEL_GUARD:   r_accel_guard   <= i_cfg_data;
                CFG_BRAKE_EMERG:   r_brake_emerg   <= i_cfg_data;
                default:           r_fresh_timeout <= r_fresh_timeout;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_now    <= i_now_time;
            r_step   <= i_step_time;
            r_pflags <= i_primary_flags;
            r_pstamp <= i_primary_stamp;
            r_psteer <= i_primary_steer;
            r_paccel <= i_primary_accel;
            r_bflags <= i_backup_flags;
            r_bstamp <= i_backup_stamp;
            r_bsteer <= i_backup_steer;
            r_baccel <= i_backup_accel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_role       <= ROLE_NONE;
            r_nrv        <= 1'b0;
            r_since      <= '0;
            r_guard_end  <= '0;
            r_prev_steer <= '0;
            r_prev_accel <= '0;
            r_have_prev  <= 1'b0;
        end else if (step_en) begin
            r_nrv   <= p_nom;
            r_since <= p_nom ? since_eff : r_since;
            r_role  <= target;
            if (target != ROLE_NONE) begin
                r_guard_end  <= n_guard_end;
                r_prev_steer <= n_steer;
                r_prev_accel <= n_accel;
                r_have_prev  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
        if (step_en) begin
            if (target == ROLE_NONE) begin
                r_cmd_valid <= 1'b0;
                r_chosen    <= ROLE_NONE;
                r_out_steer <= '0;
                r_out_accel <= '0;
                r_in_guard  <= 1'b0;
                r_reason    <= RSN_ALL_LOST;
            end else begin
                r_cmd_valid <= 1'b1;
                r_chosen    <= target;
                r_out_steer <= n_steer;
                r_out_accel <= n_accel;
                r_in_guard  <= guard;
                r_reason    <= reason;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_cmd_valid   = r_cmd_valid;
    assign o_chosen_role = r_chosen;
    assign o_out_steer   = r_out_steer;
    assign o_out_accel   = r_out_accel;
    assign o_in_guard    = r_in_guard;
    assign o_reason_code = r_reason;

`ifndef SYNTHESIS
    a_lost_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_cmd_valid) |-> (r_chosen == ROLE_NONE && r_reason == RSN_ALL_LOST))
        else $error("lost result carries a role or wrong reason");

    a_cmd_has_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_cmd_valid) |-> (r_chosen != ROLE_NONE))
        else $error("issued command without a role");

    a_role_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_en |=> (r_role == r_chosen))
        else $error("active role differs from reported role");

    a_prev_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have_prev |=> r_have_prev)
        else $error("previous output flag dropped without reset");

    a_since_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nrv && $past(r_nrv) && $past(i_rst_n)) |-> $stable(r_since))
        else $error("nominal start time moved during a nominal run");
`endif

endmodule
